/* rtl/median_nearest_color_classifier_defines.svh */
// ----------------------------------------------------------------------------
// Median nearest color classifier: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_NEAREST_COLOR_CLASSIFIER_DEFINES_SVH
`define MEDIAN_NEAREST_COLOR_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define MNCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MNCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mncc_pkg.sv */
// ----------------------------------------------------------------------------
// mncc_pkg
// Shared widths, types and codes of the median nearest color classifier.
// ----------------------------------------------------------------------------
package mncc_pkg;

  localparam int SAMPLE_COUNT = 9;
  localparam int IDX_W        = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int RANK_W       = $clog2(SAMPLE_COUNT + 1);
  localparam int MID_INDEX    = (SAMPLE_COUNT - 1) / 2;

  localparam int READ_W   = 10;
  localparam int NUM_CH   = 4;
  localparam int NUM_REFS = 7;
  localparam int REF_W    = 3 * READ_W;
  localparam int REF_IDX_W = 3;
  localparam int CLASS_W  = 3;
  localparam int SQ_W     = 2 * READ_W;
  localparam int DIST_W   = SQ_W + 2;

  // Channel slots inside one sample word
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_WHITE = 3;

  // Class codes
  localparam logic [CLASS_W-1:0] CLS_RED    = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_GREEN  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_BLUE   = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_YELLOW = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_BROWN  = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_WHITE  = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_BLACK  = 3'd6;

  // Reference red: r = g = b = 725
  localparam logic [REF_W-1:0] REF_RED_RESET = 30'd760960725;

  typedef logic [NUM_CH-1:0][READ_W-1:0] sample_t;
  typedef logic [NUM_REFS-1:0][REF_W-1:0] ref_array_t;

endpackage

/* rtl/median_nearest_color_classifier.sv */
// ----------------------------------------------------------------------------
// median_nearest_color_classifier
// Median-filtered nearest-reference color classifier, top level.
// ----------------------------------------------------------------------------
// Each input word carries one red, green, blue and white sensor reading. An
// input word that does not close a round is taken whenever the block is idle
// and written to the sample memory. The word that closes a round of
// SAMPLE_COUNT readings starts a median pass and holds in_stall high until the
// result is loaded: the rank scan compares each sample with every sample
// through the sample memory's two read ports, then the distance search steps
// through the references one by one. The result word (class and four medians)
// sits in an output register; readings of the next round are taken while it
// waits, but the round-closing word is stalled until the previous result is
// gone. Reference colors are to be written through the cfg port only while
// the block is idle; the block itself does not enforce this. Index 7 is
// ignored.
// ----------------------------------------------------------------------------
`include "median_nearest_color_classifier_defines.svh"

module median_nearest_color_classifier (
  input  logic                            clk,
  input  logic                            rst,
  // Reading words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mncc_pkg::READ_W-1:0]     red_reading,
  input  logic [mncc_pkg::READ_W-1:0]     green_reading,
  input  logic [mncc_pkg::READ_W-1:0]     blue_reading,
  input  logic [mncc_pkg::READ_W-1:0]     white_reading,
  // Reference color writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mncc_pkg::REF_IDX_W-1:0]  cfg_index,
  input  logic [mncc_pkg::REF_W-1:0]      cfg_data,
  // Result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mncc_pkg::CLASS_W-1:0]    color_class,
  output logic [mncc_pkg::READ_W-1:0]     median_red,
  output logic [mncc_pkg::READ_W-1:0]     median_green,
  output logic [mncc_pkg::READ_W-1:0]     median_blue,
  output logic [mncc_pkg::READ_W-1:0]     median_white
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RANK = 2'd1;
  localparam logic [1:0] ST_DIST = 2'd2;

  localparam logic [mncc_pkg::IDX_W-1:0] LAST_IDX =
    mncc_pkg::IDX_W'(mncc_pkg::SAMPLE_COUNT - 1);

  logic [1:0]                   state;
  logic [mncc_pkg::IDX_W-1:0]   sample_count;
  logic                         in_accept;
  logic                         round_end;
  logic                         rank_start;
  mncc_pkg::sample_t            in_word;
  mncc_pkg::ref_array_t         refs;

  logic [mncc_pkg::IDX_W-1:0]   cand_addr;
  logic [mncc_pkg::IDX_W-1:0]   peer_addr;
  mncc_pkg::sample_t            cand_data;
  mncc_pkg::sample_t            peer_data;
  logic                         rank_done;
  mncc_pkg::sample_t            medians;
  logic                         dist_done;
  logic [mncc_pkg::CLASS_W-1:0] dist_class;

  // Only the round-closing word has to wait for the output register.
  assign in_stall  = (state != ST_IDLE) || (out_valid && (sample_count == LAST_IDX));
  assign in_accept = in_valid && !in_stall;
  assign round_end = in_accept && (sample_count == LAST_IDX);
  assign cfg_ready = 1'b1;

  always_comb begin
    in_word                     = '0;
    in_word[mncc_pkg::CH_RED]   = red_reading;
    in_word[mncc_pkg::CH_GREEN] = green_reading;
    in_word[mncc_pkg::CH_BLUE]  = blue_reading;
    in_word[mncc_pkg::CH_WHITE] = white_reading;
  end

  // Reference color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      refs <= {{((mncc_pkg::NUM_REFS - 1) * mncc_pkg::REF_W){1'b0}},
               mncc_pkg::REF_RED_RESET};
    end else if (cfg_valid && cfg_ready) begin
      for (int k = 0; k < mncc_pkg::NUM_REFS; k++) begin
        if (cfg_index == mncc_pkg::REF_IDX_W'(k)) begin
          refs[k] <= cfg_data;
        end
      end
    end
  end

  // Round sequencer: collect, rank, search, then back to collecting
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_count <= '0;
      rank_start   <= 1'b0;
    end else begin
      rank_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (round_end) begin
            sample_count <= '0;
            rank_start   <= 1'b1;
            state        <= ST_RANK;
          end else if (in_accept) begin
            sample_count <= sample_count + 1'b1;
          end
        end
        ST_RANK: begin
          if (rank_done) begin
            state <= ST_DIST;
          end
        end
        ST_DIST: begin
          if (dist_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  mncc_sample_ram u_ram (
    .clk     (clk),
    .we      (in_accept),
    .waddr   (sample_count),
    .wdata   (in_word),
    .raddr_a (cand_addr),
    .raddr_b (peer_addr),
    .rdata_a (cand_data),
    .rdata_b (peer_data)
  );

  mncc_median u_median (
    .clk       (clk),
    .rst       (rst),
    .start     (rank_start),
    .cand_data (cand_data),
    .peer_data (peer_data),
    .cand_addr (cand_addr),
    .peer_addr (peer_addr),
    .done      (rank_done),
    .medians   (medians)
  );

  mncc_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .start       (rank_done),
    .refs        (refs),
    .medians     (medians),
    .done        (dist_done),
    .color_class (dist_class)
  );

  // Output register: load on search done, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dist_done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_done) begin
      color_class  <= dist_class;
      median_red   <= medians[mncc_pkg::CH_RED];
      median_green <= medians[mncc_pkg::CH_GREEN];
      median_blue  <= medians[mncc_pkg::CH_BLUE];
      median_white <= medians[mncc_pkg::CH_WHITE];
    end
  end

  `MNCC_ASSERT_NOW(a_busy_stalls, state != ST_IDLE, in_stall, "input taken during median pass")
  `MNCC_ASSERT_NEXT(a_round_starts_rank, round_end, state == ST_RANK, "round end missed")
  `MNCC_ASSERT_NOW(a_class_range, out_valid, color_class <= mncc_pkg::CLS_BLACK, "bad class")
  `MNCC_ASSERT_NOW(a_load_free, dist_done, !out_valid, "result overwrites pending word")

endmodule

/* rtl/mncc_sample_ram.sv */
// ----------------------------------------------------------------------------
// mncc_sample_ram
// Sample store of one round: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mncc_sample_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [mncc_pkg::IDX_W-1:0] waddr,
  input  mncc_pkg::sample_t        wdata,
  input  logic [mncc_pkg::IDX_W-1:0] raddr_a,
  input  logic [mncc_pkg::IDX_W-1:0] raddr_b,
  output mncc_pkg::sample_t        rdata_a,
  output mncc_pkg::sample_t        rdata_b
);

  mncc_pkg::sample_t mem [mncc_pkg::SAMPLE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/mncc_median.sv */
// ----------------------------------------------------------------------------
// mncc_median
// Rank scan over the sample store: each entry in turn is the candidate and
// is compared with every entry; the one whose stable rank is the middle
// index is that channel's median.
// ----------------------------------------------------------------------------
module mncc_median (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  mncc_pkg::sample_t          cand_data,
  input  mncc_pkg::sample_t          peer_data,
  output logic [mncc_pkg::IDX_W-1:0] cand_addr,
  output logic [mncc_pkg::IDX_W-1:0] peer_addr,
  output logic                       done,
  output mncc_pkg::sample_t          medians
);

  localparam logic [mncc_pkg::IDX_W-1:0] LAST_IDX =
    mncc_pkg::IDX_W'(mncc_pkg::SAMPLE_COUNT - 1);
  localparam logic [mncc_pkg::RANK_W-1:0] MID_RANK =
    mncc_pkg::RANK_W'(mncc_pkg::MID_INDEX);

  logic                       busy;
  logic                       waiting;
  logic [mncc_pkg::IDX_W-1:0] cand;
  logic [mncc_pkg::IDX_W-1:0] peer;
  logic [mncc_pkg::IDX_W-1:0] peer_d;
  logic                       cmp_valid;
  logic                       cmp_last;
  logic [mncc_pkg::NUM_CH-1:0][mncc_pkg::RANK_W-1:0] rank;
  logic [mncc_pkg::NUM_CH-1:0][mncc_pkg::RANK_W-1:0] rank_next;

  assign cand_addr = cand;
  assign peer_addr = peer;

  // Count peers that sort ahead of the candidate; ties go by entry order.
  always_comb begin
    for (int c = 0; c < mncc_pkg::NUM_CH; c++) begin
      if ((peer_data[c] < cand_data[c]) ||
          ((peer_data[c] == cand_data[c]) && (peer_d < cand))) begin
        rank_next[c] = rank[c] + 1'b1;
      end else begin
        rank_next[c] = rank[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      waiting   <= 1'b0;
      cand      <= '0;
      peer      <= '0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
      done      <= 1'b0;
      rank      <= '0;
    end else begin
      done      <= 1'b0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        waiting <= 1'b0;
        cand    <= '0;
        peer    <= '0;
        rank    <= '0;
      end else if (busy) begin
        // Issue side: walk the peer address across the store
        if (!waiting) begin
          cmp_valid <= 1'b1;
          cmp_last  <= (peer == LAST_IDX);
          if (peer == LAST_IDX) begin
            waiting <= 1'b1;
            peer    <= '0;
          end else begin
            peer <= peer + 1'b1;
          end
        end
        // Compare side: follows the issue side in the next cycle
        if (cmp_valid) begin
          if (cmp_last) begin
            rank <= '0;
            if (cand == LAST_IDX) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              cand    <= cand + 1'b1;
              waiting <= 1'b0;
            end
          end else begin
            rank <= rank_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    peer_d <= peer;
    if (cmp_valid && cmp_last) begin
      for (int c = 0; c < mncc_pkg::NUM_CH; c++) begin
        if (rank_next[c] == MID_RANK) begin
          medians[c] <= cand_data[c];
        end
      end
    end
  end

endmodule

/* rtl/mncc_dist.sv */
// ----------------------------------------------------------------------------
// mncc_dist
// Nearest reference search: one reference a cycle, squares registered,
// then summed and compared against the best so far.
// ----------------------------------------------------------------------------
module mncc_dist (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  mncc_pkg::ref_array_t         refs,
  input  mncc_pkg::sample_t            medians,
  output logic                         done,
  output logic [mncc_pkg::CLASS_W-1:0] color_class
);

  localparam logic [mncc_pkg::CLASS_W-1:0] LAST_REF =
    mncc_pkg::CLASS_W'(mncc_pkg::NUM_REFS - 1);

  logic                          busy;
  logic [mncc_pkg::CLASS_W-1:0]  ref_sel;
  logic [mncc_pkg::REF_W-1:0]    ref_word;
  logic [2:0][mncc_pkg::READ_W-1:0] ref_ch;
  logic [2:0][mncc_pkg::READ_W-1:0] diff;
  logic [2:0][mncc_pkg::SQ_W-1:0]   sq;
  logic                          sq_valid;
  logic [mncc_pkg::CLASS_W-1:0]  sq_ref;
  logic [mncc_pkg::DIST_W-1:0]   dist_sum;
  logic [mncc_pkg::DIST_W-1:0]   best;

  assign ref_word  = refs[ref_sel];
  assign ref_ch[0] = ref_word[3*mncc_pkg::READ_W-1 -: mncc_pkg::READ_W];
  assign ref_ch[1] = ref_word[2*mncc_pkg::READ_W-1 -: mncc_pkg::READ_W];
  assign ref_ch[2] = ref_word[mncc_pkg::READ_W-1:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = (ref_ch[c] > medians[c]) ? (ref_ch[c] - medians[c])
                                         : (medians[c] - ref_ch[c]);
    end
  end

  assign dist_sum = mncc_pkg::DIST_W'(sq[0]) + mncc_pkg::DIST_W'(sq[1]) +
                    mncc_pkg::DIST_W'(sq[2]);

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sq[c] <= mncc_pkg::SQ_W'(diff[c]) * mncc_pkg::SQ_W'(diff[c]);
    end
    sq_ref <= ref_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      ref_sel  <= '0;
      sq_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      sq_valid <= busy;
      if (start) begin
        busy    <= 1'b1;
        ref_sel <= '0;
      end else if (busy) begin
        if (ref_sel == LAST_REF) begin
          busy <= 1'b0;
        end else begin
          ref_sel <= ref_sel + 1'b1;
        end
      end
      if (sq_valid && (sq_ref == LAST_REF)) begin
        done <= 1'b1;
      end
    end
  end

  // First strictly smaller distance wins
  always_ff @(posedge clk) begin
    if (sq_valid) begin
      if ((sq_ref == mncc_pkg::CLS_RED) || (dist_sum < best)) begin
        best        <= dist_sum;
        color_class <= sq_ref;
      end
    end
  end

endmodule
